// ----- design/hcr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the Harris corner response block.
// Used by every module of the block; depends on nothing.
package hcr_pkg;

    // Half width of the Gaussian window. The window datapath is built for this size.
    localparam int WIN_HALF = 5;
    localparam int EDGE     = WIN_HALF + 1;
    localparam int FULL     = 2 * EDGE;
    localparam int MIN_SIZE = 2 * EDGE + 1;

    // Gaussian taps in unsigned Q0.16, center first. The outermost tap is the smallest.
    localparam logic [15:0] GAUSS_Q16 [5] = '{16'd26145, 16'd15857, 16'd3538, 16'd290, 16'd8};

    localparam int DC_W   = 13;
    localparam int QDEPTH = 4;
    localparam int QPW    = 2;
    localparam int QCW    = 3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ALPHA  = 2'd2;

    typedef logic [2:0][20:0]      t_trio;
    typedef logic [8:0][2:0][20:0] t_win;

    typedef struct packed {
        logic        valid;
        logic        vert;
        logic        emit;
        logic [10:0] row;
        logic [10:0] col;
        logic        fe;
    } t_tag;

    typedef struct packed {
        logic signed [10:0] ix;
        logic signed [10:0] iy;
        logic [DC_W-1:0]    dc;
        t_tag               tag;
    } t_qitem;

endpackage

// ----- design/hcr_front.sv -----
`timescale 1ns / 1ps
// Front end: pixel position tracking, pixel and box-sum line stores, derivatives.
// Depends on hcr_pkg.
module hcr_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [7:0]          i_pixel,
    input  logic                i_fs,
    input  logic [11:0]         i_width,
    input  logic [11:0]         i_height,
    output logic                o_push,
    output hcr_pkg::t_qitem     o_item
);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int RHW = $clog2(MAX_HEIGHT);
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
    localparam int HW  = ($clog2(MAX_HEIGHT + 1) > 12) ? $clog2(MAX_HEIGHT + 1) : 12;

    logic [WW-1:0]  cfg_w, w_eff, c1;
    logic [HW-1:0]  cfg_h, h_eff, row_t, nr;
    logic [AW-1:0]  col0, c, cc, n_col;
    logic [RHW-1:0] row0, r, n_row;
    logic           fe0;

    logic [AW-1:0]  r_col, r_c;
    logic [RHW-1:0] r_row, r_r;
    logic           r_f1_v, r_fe;
    logic [7:0]     r_p, r_pt0, r_pt1;
    logic [9:0]     r_cst0, r_cst1;

    logic [15:0] pix_mem [MAX_WIDTH];
    logic [19:0] box_mem [MAX_WIDTH];
    logic [15:0] r_pix_rd, r_pix_fw, pix_word, n_pix_wd;
    logic [19:0] r_box_rd, r_box_fw, box_word, n_box_wd;
    logic        r_pix_hit, r_box_hit;

    logic [AW-1:0]      r_cc;
    logic               c_ge2, r_ge2, c_full, r_full, pix_we, box_we;
    logic [9:0]         vsum, hsum, hold;
    logic signed [10:0] ix, iy;

    // Position of the accepted pixel and the position that follows it.
    always_comb begin
        cfg_w = WW'(i_width);
        cfg_h = HW'(i_height);
        w_eff = (cfg_w < WW'(hcr_pkg::MIN_SIZE)) ? WW'(hcr_pkg::MIN_SIZE) :
                (cfg_w > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : cfg_w;
        h_eff = (cfg_h < HW'(hcr_pkg::MIN_SIZE)) ? HW'(hcr_pkg::MIN_SIZE) :
                (cfg_h > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : cfg_h;
        col0  = i_fs ? '0 : r_col;
        row0  = i_fs ? '0 : r_row;
        row_t = HW'(row0);
        c     = col0;
        if (WW'(col0) >= w_eff) begin
            c     = '0;
            row_t = HW'(row0) + HW'(1);
        end
        if (row_t >= h_eff) begin
            row_t = '0;
        end
        r     = row_t[RHW-1:0];
        cc    = c - AW'(2);
        fe0   = (HW'(r) == h_eff - HW'(1)) && (WW'(c) == w_eff - WW'(1));
        c1    = WW'(c) + WW'(1);
        n_col = c1[AW-1:0];
        n_row = r;
        if (c1 >= w_eff) begin
            n_col = '0;
            nr    = HW'(r) + HW'(1);
            n_row = (nr >= h_eff) ? '0 : nr[RHW-1:0];
        end else begin
            nr    = HW'(r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_f1_v <= 1'b0;
        end else begin
            r_f1_v <= i_acc;
            if (i_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_p  <= i_pixel;
            r_c  <= c;
            r_r  <= r;
            r_fe <= fe0;
        end
    end

    // Line stores, read on accept and written in the cycle after it, with a bypass
    // for a read of the entry that is being written.
    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            pix_mem[r_c] <= n_pix_wd;
        end
        if (box_we) begin
            box_mem[r_cc] <= n_box_wd;
        end
        if (i_acc) begin
            r_pix_rd  <= pix_mem[c];
            r_box_rd  <= box_mem[cc];
            r_pix_hit <= pix_we && (r_c == c);
            r_box_hit <= box_we && (r_cc == cc);
            r_pix_fw  <= n_pix_wd;
            r_box_fw  <= n_box_wd;
        end
    end

    always_comb begin
        r_cc     = r_c - AW'(2);
        c_ge2    = r_c >= AW'(2);
        r_ge2    = r_r >= RHW'(2);
        c_full   = r_c >= AW'(hcr_pkg::FULL);
        r_full   = r_r >= RHW'(hcr_pkg::FULL);
        pix_word = r_pix_hit ? r_pix_fw : r_pix_rd;
        box_word = r_box_hit ? r_box_fw : r_box_rd;
        vsum     = r_ge2 ? (10'(pix_word[15:8]) + 10'(pix_word[7:0]) + 10'(r_p)) : 10'd0;
        hsum     = 10'(r_pt0) + 10'(r_pt1) + 10'(r_p);
        hold     = box_word[19:10];
        n_pix_wd = {pix_word[7:0], r_p};
        n_box_wd = {box_word[9:0], hsum};
        pix_we   = r_f1_v;
        box_we   = r_f1_v && c_ge2;
        ix       = 11'(hsum) - 11'(hold);
        iy       = 11'(vsum) - 11'(r_cst1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt0  <= '0;
            r_pt1  <= '0;
            r_cst0 <= '0;
            r_cst1 <= '0;
        end else if (r_f1_v) begin
            r_pt1  <= r_pt0;
            r_pt0  <= r_p;
            r_cst1 <= r_cst0;
            r_cst0 <= vsum;
        end
    end

    always_comb begin
        o_push           = r_f1_v && c_ge2 && r_ge2;
        o_item.ix        = ix;
        o_item.iy        = iy;
        o_item.dc        = hcr_pkg::DC_W'(r_cc);
        o_item.tag.valid = 1'b1;
        o_item.tag.vert  = r_full;
        o_item.tag.emit  = r_full && c_full;
        o_item.tag.row   = 11'(16'(r_r) - 16'(hcr_pkg::EDGE));
        o_item.tag.col   = 11'(16'(r_c) - 16'(hcr_pkg::EDGE));
        o_item.tag.fe    = r_fe;
    end

endmodule

// ----- design/hcr_queue.sv -----
`timescale 1ns / 1ps
// Short queue of derivative items between the front and back ends.
// Depends on hcr_pkg.
module hcr_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  hcr_pkg::t_qitem          i_item,
    input  logic                     i_pop,
    output hcr_pkg::t_qitem          o_item,
    output logic                     o_nonempty,
    output logic [hcr_pkg::QCW-1:0]  o_count
);
    hcr_pkg::t_qitem             r_mem [hcr_pkg::QDEPTH];
    logic [hcr_pkg::QPW-1:0]     r_wp, r_rp;
    logic [hcr_pkg::QCW-1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + hcr_pkg::QPW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + hcr_pkg::QPW'(1);
            end
            r_count <= r_count + hcr_pkg::QCW'(i_push) - hcr_pkg::QCW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item     = r_mem[r_rp];
    assign o_nonempty = r_count != '0;
    assign o_count    = r_count;

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count < hcr_pkg::QCW'(hcr_pkg::QDEPTH))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue pop while empty");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + hcr_pkg::QCW'(1))
        else $error("queue count lost a push");
`endif

endmodule

// ----- design/hcr_gauss.sv -----
`timescale 1ns / 1ps
// Three-stage 1-D Gaussian weighting of nine symmetric samples on three channels.
// Depends on hcr_pkg.
module hcr_gauss (
    input  logic           i_clk,
    input  logic           i_en,
    input  hcr_pkg::t_win  i_win,
    output hcr_pkg::t_trio o_res
);
    logic signed [21:0] r_pair [3][5];
    logic signed [37:0] r_term [3][5];
    logic signed [40:0] sum [3];
    hcr_pkg::t_trio     r_res;

    always_comb begin
        for (int m = 0; m < 3; m++) begin
            sum[m] = 41'(r_term[m][0]) + 41'(r_term[m][1]) + 41'(r_term[m][2])
                   + 41'(r_term[m][3]) + 41'(r_term[m][4]);
        end
    end

    // Samples j and 8-j share a tap; sample 4 is the center.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < 3; m++) begin
                for (int j = 0; j < 4; j++) begin
                    r_pair[m][j] <= 22'($signed(i_win[j][m])) + 22'($signed(i_win[8-j][m]));
                end
                r_pair[m][4] <= 22'($signed(i_win[4][m]));
                for (int j = 0; j < 5; j++) begin
                    r_term[m][j] <= 38'(r_pair[m][j])
                                  * 38'($signed({1'b0, hcr_pkg::GAUSS_Q16[4-j]}));
                end
                r_res[m] <= sum[m][36:16];
            end
        end
    end

    assign o_res = r_res;

endmodule

// ----- design/hcr_back.sv -----
`timescale 1ns / 1ps
// Back end: product line store, vertical and horizontal Gaussian passes, response.
// Depends on hcr_pkg and hcr_gauss.
module hcr_back #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_qv,
    input  hcr_pkg::t_qitem i_item,
    output logic            o_pop,
    input  logic [15:0]     i_alpha,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [47:0]     o_resp,
    output logic [10:0]     o_row,
    output logic [10:0]     o_col,
    output logic            o_fe
);
    localparam int AW = $clog2(MAX_WIDTH);

    hcr_pkg::t_tag  r_tag [1:11];
    hcr_pkg::t_win  prod_mem [MAX_WIDTH];
    hcr_pkg::t_win  r_prd, n_wd, r_tap;
    hcr_pkg::t_trio prod, vp, a;

    logic               adv, wr;
    logic signed [10:0] r_ix, r_iy;
    logic [AW-1:0]      r_dc;
    logic signed [20:0] a0, a1, a2;
    logic [20:0]        tr;
    logic signed [41:0] r_p01, r_p22;
    logic [41:0]        r_tr2;
    logic signed [42:0] r_det, r_det2;
    logic [36:0]        r_alo, r_ahi;
    logic [57:0]        asum;
    logic [41:0]        r_at;
    logic signed [44:0] diff;
    logic [44:0]        mag;
    logic [47:0]        r_resp;

    assign adv   = !(r_tag[11].valid && r_tag[11].emit) || i_ready;
    assign o_pop = adv && i_qv;
    assign wr    = adv && r_tag[1].valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 11; k++) begin
                r_tag[k] <= '0;
            end
        end else if (adv) begin
            r_tag[1] <= o_pop ? i_item.tag : '0;
            for (int k = 2; k <= 11; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // Each word holds the last nine rows of one column, newest first.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prd <= prod_mem[i_item.dc[AW-1:0]];
            r_ix  <= i_item.ix;
            r_iy  <= i_item.iy;
            r_dc  <= i_item.dc[AW-1:0];
        end
        if (wr) begin
            prod_mem[r_dc] <= n_wd;
        end
    end

    always_comb begin
        prod[0] = 21'(r_ix) * 21'(r_ix);
        prod[1] = 21'(r_iy) * 21'(r_iy);
        prod[2] = 21'(r_ix) * 21'(r_iy);
        n_wd    = {r_prd[7:0], prod};
    end

    hcr_gauss u_vert (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_win (r_prd),
        .o_res (vp)
    );

    // Vertical results of the nine previous columns, newest first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else if (adv && r_tag[4].valid && r_tag[4].vert) begin
            r_tap <= {r_tap[7:0], vp};
        end
    end

    hcr_gauss u_horz (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_win (r_tap),
        .o_res (a)
    );

    always_comb begin
        a0   = $signed(a[0]);
        a1   = $signed(a[1]);
        a2   = $signed(a[2]);
        tr   = a[0] + a[1];
        asum = {r_ahi, 21'd0} + 58'(r_alo);
        diff = 45'(r_det2) - $signed({3'd0, r_at});
        mag  = diff[44] ? 45'(-diff) : 45'(diff);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p01  <= 42'(a0) * 42'(a1);
            r_p22  <= 42'(a2) * 42'(a2);
            r_tr2  <= 42'(tr) * 42'(tr);
            r_det  <= 43'(r_p01) - 43'(r_p22);
            r_alo  <= 37'(i_alpha) * 37'(r_tr2[20:0]);
            r_ahi  <= 37'(i_alpha) * 37'(r_tr2[41:21]);
            r_at   <= asum[57:16];
            r_det2 <= r_det;
            r_resp <= 48'(mag);
        end
    end

    assign o_valid = r_tag[11].valid && r_tag[11].emit;
    assign o_resp  = r_resp;
    assign o_row   = r_tag[11].row;
    assign o_col   = r_tag[11].col;
    assign o_fe    = r_tag[11].fe;

endmodule

// ----- design/harris_corner_response.sv -----
`timescale 1ns / 1ps
// Top level of the Harris corner response block: configuration registers and
// the front end, queue and back end. Depends on hcr_pkg and all hcr_ modules.
//
//  channel   direction  handshake                     payload
//  s stream  in         i_s_tvalid / o_s_tready       i_s_tdata: pixel; i_s_tuser: frame_start
//  m stream  out        o_m_tvalid / i_m_tready       o_m_tdata: response,row,col; o_m_tlast
//  config    in         i_cfg_wr_en                   i_cfg_index, i_cfg_wdata
//
// One pixel is taken per clock cycle while results drain. A pixel is registered
// once in the front end and enters the queue at the next edge; its item then
// passes the eleven back-end stages before o_m_tvalid rises, unless a stall
// holds it.
// Reset is synchronous and active low; the line stores need no clearing pass.
// A stalled result freezes the back-end pipeline; the four-entry queue then
// fills and o_s_tready falls once three of its entries are taken.
module harris_corner_response #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] pixel
    input  logic [0:0]  i_s_tuser,   // [0] frame_start
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [47:0] response, [58:48] out_row, [69:59] out_col
    output logic        o_m_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    logic [11:0] r_width, r_height;
    logic [15:0] r_alpha;

    logic                    acc, push, pop, q_nonempty;
    hcr_pkg::t_qitem         f_item, q_item;
    logic [hcr_pkg::QCW-1:0] q_count;
    logic [47:0]             resp;
    logic [10:0]             orow, ocol;

    // Configuration writes take effect at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 12'd480;
            r_alpha  <= 16'd3932;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                hcr_pkg::CFG_WIDTH:  r_width  <= i_cfg_wdata[11:0];
                hcr_pkg::CFG_HEIGHT: r_height <= i_cfg_wdata[11:0];
                hcr_pkg::CFG_ALPHA:  r_alpha  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Two free queue entries cover the item in the front end and the one accepted now.
    assign o_s_tready = q_count <= hcr_pkg::QCW'(hcr_pkg::QDEPTH - 2);
    assign acc        = i_s_tvalid && o_s_tready;

    hcr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_pixel  (i_s_tdata),
        .i_fs     (i_s_tuser[0]),
        .i_width  (r_width),
        .i_height (r_height),
        .o_push   (push),
        .o_item   (f_item)
    );

    hcr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (f_item),
        .i_pop      (pop),
        .o_item     (q_item),
        .o_nonempty (q_nonempty),
        .o_count    (q_count)
    );

    hcr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qv    (q_nonempty),
        .i_item  (q_item),
        .o_pop   (pop),
        .i_alpha (r_alpha),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_resp  (resp),
        .o_row   (orow),
        .o_col   (ocol),
        .o_fe    (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, ocol, orow, resp};

endmodule

// ----- test/harris_corner_response_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for harris_corner_response: a directed table of frames
// and a random part, each result checked against a behavioral predictor.
// Depends on hcr_pkg and the harris_corner_response RTL.
module harris_corner_response_tb;

    localparam int MAXW      = 2048;
    localparam int MAXH      = 2048;
    localparam int SPAN      = 10;
    localparam int SETTLE    = 30;          // cycles to let the pipeline drain
    localparam int CYCLE_CAP = 3000000;

    // Test image patterns used by the directed table.
    typedef enum int {PAT_FLAT0, PAT_FLAT255, PAT_CHECKER, PAT_RAMP, PAT_RANDOM} t_pattern;

    // One directed phase: optional register writes, then a run of pixels.
    typedef struct {
        bit        do_cfg;
        int        width;
        int        height;
        int        alpha;
        t_pattern  pattern;
        int        npix;
        int        restart_at;   // a second frame_start at this item, or -1
        bit        zero_known;   // a flat image gives a response of zero
    } t_phase;

    typedef struct {
        logic [47:0] response;
        logic [10:0] row;
        logic [10:0] col;
        logic        frame_end;
    } t_corner;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic [0:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;

    harris_corner_response DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the block's line stores, taps,
    // position counters and registers.
    // ------------------------------------------------------------------
    logic [7:0]  pix_line  [0:2*MAXW-1];
    logic [9:0]  box_line  [0:2*MAXW-1];
    int          prod_line [0:SPAN*MAXW-1][0:2];
    logic [7:0]  pix_tap   [0:1];
    logic [9:0]  vsum_tap  [0:1];
    int          win_tap   [0:SPAN-1][0:2];
    int          cur_row, cur_col;
    logic [11:0] reg_width  = 12'd640;
    logic [11:0] reg_height = 12'd480;
    logic [15:0] reg_alpha  = 16'd3932;

    t_corner corners_due[$];
    int      mismatches = 0;
    int      corners_seen = 0;
    bit      gaps_on = 1'b1;
    bit      zero_known = 1'b0;

    // Gaussian tap for distance d from the window center; the outer tap is zero.
    function automatic longint gauss_tap(int k);
        int d;
        d = (k < 5) ? 5 - k : k - 5;
        case (d)
            0: return 26145;
            1: return 15857;
            2: return 3538;
            3: return 290;
            4: return 8;
            default: return 0;
        endcase
    endfunction

    function automatic int size_in_use(logic [11:0] v, int hi);
        if (v < hcr_pkg::MIN_SIZE) return hcr_pkg::MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advances the predictor by one pixel. Returns 1 and fills the expected
    // corner when the pixel completes a Gaussian window.
    function automatic bit harris_step(logic [7:0] p, bit fs, output t_corner res);
        int w, h, r, c, cc, dr, dc, vsum, hsum, hold, ix, iy, slot;
        int prod[3], vp[3], a[3];
        longint s, det, diff;
        longint unsigned tr, at, mag;
        bit made;
        made = 0;
        res = '{default: '0};
        w = size_in_use(reg_width, MAXW);
        h = size_in_use(reg_height, MAXH);
        if (fs) begin
            cur_row = 0;
            cur_col = 0;
        end
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= h) cur_row = 0;
        r = cur_row;
        c = cur_col;

        vsum = 0;
        if (r >= 2) vsum = pix_line[MAXW + c] + pix_line[c] + p;
        pix_line[MAXW + c] = pix_line[c];
        pix_line[c] = p;

        if (c >= 2) begin
            cc = c - 2;
            hsum = pix_tap[1] + pix_tap[0] + p;
            hold = box_line[MAXW + cc];
            box_line[MAXW + cc] = box_line[cc];
            box_line[cc] = hsum;
            if (r >= 2) begin
                dr = r - 2;
                dc = cc;
                ix = hsum - hold;
                iy = vsum - vsum_tap[1];
                slot = dr % SPAN;
                prod[0] = ix * ix;
                prod[1] = iy * iy;
                prod[2] = ix * iy;
                if (dr >= SPAN) begin
                    // Vertical pass over the ten stored rows and the new one.
                    for (int m = 0; m < 3; m++) begin
                        s = gauss_tap(SPAN) * prod[m];
                        for (int k = 0; k < SPAN; k++)
                            s += gauss_tap(k) * prod_line[((dr + k) % SPAN) * MAXW + dc][m];
                        vp[m] = int'(s >>> 16);
                    end
                end
                for (int m = 0; m < 3; m++) prod_line[slot * MAXW + dc][m] = prod[m];
                if (dr >= SPAN) begin
                    if (dc >= SPAN) begin
                        // Horizontal pass, then det - alpha * trace^2.
                        for (int m = 0; m < 3; m++) begin
                            s = gauss_tap(SPAN) * vp[m];
                            for (int k = 0; k < SPAN; k++)
                                s += gauss_tap(k) * win_tap[SPAN - 1 - k][m];
                            a[m] = int'(s >>> 16);
                        end
                        det = longint'(a[0]) * a[1] - longint'(a[2]) * a[2];
                        tr = longint'(a[0]) + a[1];
                        at = (longint'(reg_alpha) * (tr * tr)) >> 16;
                        diff = det - longint'(at);
                        mag = (diff < 0) ? -diff : diff;
                        if (mag > 64'hFFFF_FFFF_FFFF) mag = 64'hFFFF_FFFF_FFFF;
                        res.response  = mag[47:0];
                        res.row       = 11'(r - hcr_pkg::EDGE);
                        res.col       = 11'(c - hcr_pkg::EDGE);
                        res.frame_end = (r == h - 1) && (c == w - 1);
                        made = 1;
                    end
                    for (int j = SPAN - 1; j > 0; j--)
                        for (int m = 0; m < 3; m++) win_tap[j][m] = win_tap[j - 1][m];
                    for (int m = 0; m < 3; m++) win_tap[0][m] = vp[m];
                end
            end
        end

        pix_tap[1] = pix_tap[0];
        pix_tap[0] = p;
        vsum_tap[1] = vsum_tap[0];
        vsum_tap[0] = vsum;
        cur_col = c + 1;
        cur_row = r;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row = r + 1;
            if (cur_row >= h) cur_row = 0;
        end
        return made;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Writes one register at a falling edge and mirrors it into the predictor.
    task automatic write_reg(logic [1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = 16'(value);
        case (idx)
            hcr_pkg::CFG_WIDTH:  reg_width  = 12'(value);
            hcr_pkg::CFG_HEIGHT: reg_height = 12'(value);
            hcr_pkg::CFG_ALPHA:  reg_alpha  = 16'(value);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Registers change only once every expected corner has come out and the
    // pipeline has had time to finish pixels that produce no corner.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (corners_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Offers one pixel; called at a falling edge, returns at the next falling
    // edge after the transaction.
    task automatic send_pixel(logic [7:0] p, bit fs, output bit made);
        t_corner res;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = p;
        i_s_tuser  = fs;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        made = harris_step(p, fs, res);
        if (made) begin
            if (zero_known) res.response = 48'd0;
            corners_due.insert(corners_due.size(), res);
        end
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pattern_pixel(t_pattern pat, int idx, int w);
        case (pat)
            PAT_FLAT0:   return 8'd0;
            PAT_FLAT255: return 8'd255;
            PAT_CHECKER: return (((idx % w) + (idx / w)) % 2) ? 8'd255 : 8'd0;
            PAT_RAMP:    return 8'((idx % w) * 16);
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Result side: random stall bursts, plus one long hold-off that lets the
    // block's queue fill while the sender keeps offering pixels.
    initial begin : receiver
        int stall_left;
        int hold_left;
        bit held_once;
        stall_left = 0;
        hold_left = 0;
        held_once = 0;
        forever begin
            @(negedge i_clk);
            if (!held_once && corners_seen >= 3) begin
                held_once = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready = 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                i_m_tready = 1'b0;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // Checks every result transaction against the oldest expected corner.
    always @(posedge i_clk) begin
        t_corner want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            corners_seen++;
            if (corners_due.size() == 0) begin
                report_mismatch("corner result with none expected");
            end else begin
                want = corners_due.pop_front();
                if (o_m_tdata[47:0] !== want.response)
                    report_mismatch($sformatf("response %0d, expected %0d",
                                              o_m_tdata[47:0], want.response));
                if (o_m_tdata[58:48] !== want.row)
                    report_mismatch($sformatf("row %0d, expected %0d",
                                              o_m_tdata[58:48], want.row));
                if (o_m_tdata[69:59] !== want.col)
                    report_mismatch($sformatf("col %0d, expected %0d",
                                              o_m_tdata[69:59], want.col));
                if (o_m_tlast !== want.frame_end)
                    report_mismatch($sformatf("frame_end %0b, expected %0b",
                                              o_m_tlast, want.frame_end));
            end
        end
    end

    // Cycle limit guards against a hung handshake.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_phase plan[$];
        int w, h, npix, rand_items, restart;
        bit made;

        for (int i = 0; i < 2 * MAXW; i++) begin
            pix_line[i] = '0;
            box_line[i] = '0;
        end
        for (int i = 0; i < SPAN * MAXW; i++)
            for (int m = 0; m < 3; m++) prod_line[i][m] = 0;
        for (int j = 0; j < SPAN; j++)
            for (int m = 0; m < 3; m++) win_tap[j][m] = 0;
        pix_tap = '{default: '0};
        vsum_tap = '{default: '0};
        cur_row = 0;
        cur_col = 0;

        // Directed frames. The first keeps the reset registers and is too short
        // for any corner; the flat image has an all-zero response by inspection.
        plan.insert(plan.size(), t_phase'{0, 640, 480, 3932, PAT_RANDOM, 20, -1, 0});
        plan.insert(plan.size(), t_phase'{1, 13, 13, 65535, PAT_FLAT255, 169, -1, 1});
        // Sizes below the minimum are used as the minimum.
        plan.insert(plan.size(), t_phase'{1, 0, 0, 3932, PAT_CHECKER, 169, -1, 0});
        // Widest line with the top register value, only its start sent.
        plan.insert(plan.size(), t_phase'{1, 4095, 13, 65535, PAT_RANDOM, 20, -1, 0});
        // Tallest frame, only partly sent; the long result hold-off falls here.
        plan.insert(plan.size(), t_phase'{1, 16, 4095, 100, PAT_RAMP, 16 * 20, -1, 0});

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            wait_idle();
            if (plan[i].do_cfg) begin
                write_reg(hcr_pkg::CFG_WIDTH,  plan[i].width);
                write_reg(hcr_pkg::CFG_HEIGHT, plan[i].height);
                write_reg(hcr_pkg::CFG_ALPHA,  plan[i].alpha);
            end
            zero_known = plan[i].zero_known;
            w = size_in_use(reg_width, MAXW);
            for (int n = 0; n < plan[i].npix; n++)
                send_pixel(pattern_pixel(plan[i].pattern, n, w),
                           n == 0 || n == plan[i].restart_at, made);
            zero_known = 0;
        end

        // Random frames of small sizes; one or two frames per single
        // frame_start, some cut short by an early frame_start.
        rand_items = 0;
        while (rand_items < 150) begin
            wait_idle();
            w = $urandom_range(13, 15);
            h = $urandom_range(13, 15);
            write_reg(hcr_pkg::CFG_WIDTH, w);
            write_reg(hcr_pkg::CFG_HEIGHT, h);
            write_reg(hcr_pkg::CFG_ALPHA, $urandom_range(0, 65535));
            npix = w * h * $urandom_range(1, 2);
            restart = ($urandom_range(0, 4) == 0) ? $urandom_range(1, npix - 1) : -1;
            for (int n = 0; n < npix; n++) begin
                if (rand_items > 60) gaps_on = 1'b0;
                send_pixel(8'($urandom_range(0, 255)), n == 0 || n == restart, made);
                rand_items++;
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/hcr_pkg.sv
design/hcr_front.sv
design/hcr_queue.sv
design/hcr_gauss.sv
design/hcr_back.sv
design/harris_corner_response.sv
test/harris_corner_response_tb.sv
